// ----- hw/rtl/ffsa_pkg.sv -----
// shared constants, types and command codes of the first-fit segment allocator
`default_nettype none
package ffsa_pkg;
	localparam int MAX_SEG   = 32;
	localparam int IDX_W     = $clog2(MAX_SEG);
	localparam int CNT_W     = IDX_W + 1;
	localparam int OFF_W     = 16;
	localparam logic [OFF_W-1:0] ARENA_RESET = 16'd1024;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_BADFREE = 2'd3;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SCAN_STEP,
		CMD_FAIL,
		CMD_MARK_EXACT,
		CMD_SPLIT_PREP,
		CMD_SHIFT_UP,
		CMD_SPLIT_FIN,
		CMD_FREE_MARK,
		CMD_MERGE,
		CMD_SHIFT_DOWN,
		CMD_SHRINK,
		CMD_PUBLISH
	} cmd_op_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_KM1,
		RD_KD,
		RD_NXT
	} rd_sel_t;

	typedef struct packed {
		cmd_op_t    op;
		rd_sel_t    rd_sel;
		logic [1:0] fail_code;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic zero_size;
		logic scan_end;
		logic fit;
		logic exact;
		logic full;
		logic hit;
		logic up_done;
		logic dn_done;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ffsa_dp.sv -----
// datapath: segment table, scan index, shift counter and result registers
`default_nettype none
module ffsa_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [ffsa_pkg::OFF_W-1:0]  cfg_wdata,
	input  wire logic                        req_type,
	input  wire logic [ffsa_pkg::OFF_W-1:0]  alloc_length,
	input  wire logic [ffsa_pkg::OFF_W-1:0]  free_offset,
	input  wire ffsa_pkg::dp_cmd_t           cmd,
	output ffsa_pkg::dp_stat_t               stat,
	output logic [1:0]                       status,
	output logic [ffsa_pkg::OFF_W-1:0]       block_offset,
	output logic [ffsa_pkg::OFF_W-1:0]       block_length
);
	localparam int IW = ffsa_pkg::IDX_W;
	localparam int CW = ffsa_pkg::CNT_W;
	localparam int OW = ffsa_pkg::OFF_W;
	localparam logic [CW-1:0] MAXC = CW'(ffsa_pkg::MAX_SEG);

	logic [OW-1:0] start_q [ffsa_pkg::MAX_SEG];
	logic [OW-1:0] len_q   [ffsa_pkg::MAX_SEG];
	logic          used_q  [ffsa_pkg::MAX_SEG];
	logic [CW-1:0] cnt_q, idx_q, k_q;
	logic [1:0]    d_q;
	logic          type_q, prev_free_q;
	logic [OW-1:0] size_q, off_q, prev_start_q, prev_len_q, cur_start_q, cur_len_q;
	logic [1:0]    res_st_q;
	logic [OW-1:0] res_off_q, res_len_q;

	logic [IW-1:0] rd_addr;
	logic [OW-1:0] e_start, e_len;
	logic          e_used;
	logic [CW-1:0] idx_p1;
	logic [CW:0]   kd_sum;
	logic          nxt_free;
	logic [OW-1:0] sum1, total;

	// table read port
	assign idx_p1 = idx_q + CW'(1);
	assign kd_sum = {1'b0, k_q} + (CW+1)'(d_q);
	always_comb begin
		case (cmd.rd_sel)
			ffsa_pkg::RD_IDX: rd_addr = idx_q[IW-1:0];
			ffsa_pkg::RD_KM1: rd_addr = IW'(k_q - CW'(1));
			ffsa_pkg::RD_KD:  rd_addr = kd_sum[IW-1:0];
			ffsa_pkg::RD_NXT: rd_addr = idx_p1[IW-1:0];
			default:          rd_addr = idx_q[IW-1:0];
		endcase
	end
	assign e_start = start_q[rd_addr];
	assign e_len   = len_q[rd_addr];
	assign e_used  = used_q[rd_addr];

	// merge arithmetic
	assign nxt_free = (idx_p1 < cnt_q) && !e_used;
	assign sum1     = cur_len_q + (nxt_free ? e_len : '0);
	assign total    = prev_free_q ? prev_len_q + sum1 : sum1;

	// status to controller
	always_comb begin
		stat.is_free   = (type_q == ffsa_pkg::REQ_FREE);
		stat.zero_size = (size_q == '0);
		stat.scan_end  = (idx_q >= cnt_q);
		stat.fit       = !e_used && (e_len >= size_q);
		stat.exact     = (e_len == size_q);
		stat.full      = (cnt_q == MAXC);
		stat.hit       = e_used && (e_start == off_q);
		stat.up_done   = (k_q <= idx_p1);
		stat.dn_done   = (d_q == 2'd0) || (kd_sum >= {1'b0, cnt_q});
	end

	// table and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ffsa_pkg::MAX_SEG; i++) begin
				start_q[i] <= '0;
				len_q[i]   <= '0;
				used_q[i]  <= 1'b0;
			end
			len_q[0] <= ffsa_pkg::ARENA_RESET;
			cnt_q    <= CW'(1);
			idx_q    <= '0;
			k_q      <= '0;
			d_q      <= '0;
		end else if (cfg_we) begin
			start_q[0] <= '0;
			len_q[0]   <= cfg_wdata;
			used_q[0]  <= 1'b0;
			cnt_q      <= CW'(1);
		end else begin
			case (cmd.op)
				ffsa_pkg::CMD_LOAD: begin
					idx_q <= '0;
				end
				ffsa_pkg::CMD_SCAN_STEP: begin
					idx_q <= idx_p1;
				end
				ffsa_pkg::CMD_MARK_EXACT: begin
					used_q[idx_q[IW-1:0]] <= 1'b1;
				end
				ffsa_pkg::CMD_SPLIT_PREP: begin
					k_q <= cnt_q;
				end
				ffsa_pkg::CMD_SHIFT_UP: begin
					start_q[k_q[IW-1:0]] <= e_start;
					len_q[k_q[IW-1:0]]   <= e_len;
					used_q[k_q[IW-1:0]]  <= e_used;
					k_q                  <= k_q - CW'(1);
				end
				ffsa_pkg::CMD_SPLIT_FIN: begin
					start_q[idx_p1[IW-1:0]] <= cur_start_q + size_q;
					len_q[idx_p1[IW-1:0]]   <= cur_len_q - size_q;
					used_q[idx_p1[IW-1:0]]  <= 1'b0;
					len_q[idx_q[IW-1:0]]    <= size_q;
					used_q[idx_q[IW-1:0]]   <= 1'b1;
					cnt_q                   <= cnt_q + CW'(1);
				end
				ffsa_pkg::CMD_FREE_MARK: begin
					used_q[idx_q[IW-1:0]] <= 1'b0;
				end
				ffsa_pkg::CMD_MERGE: begin
					if (prev_free_q) begin
						len_q[IW'(idx_q - CW'(1))] <= total;
						k_q                        <= idx_q;
					end else begin
						len_q[idx_q[IW-1:0]] <= total;
						k_q                  <= idx_p1;
					end
					d_q <= {1'b0, prev_free_q} + {1'b0, nxt_free};
				end
				ffsa_pkg::CMD_SHIFT_DOWN: begin
					start_q[k_q[IW-1:0]] <= e_start;
					len_q[k_q[IW-1:0]]   <= e_len;
					used_q[k_q[IW-1:0]]  <= e_used;
					k_q                  <= k_q + CW'(1);
				end
				ffsa_pkg::CMD_SHRINK: begin
					cnt_q <= cnt_q - CW'(d_q);
				end
				default: begin
				end
			endcase
		end
	end

	// request, scan history and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ffsa_pkg::CMD_LOAD: begin
				type_q      <= req_type;
				size_q      <= alloc_length;
				off_q       <= free_offset;
				prev_free_q <= 1'b0;
			end
			ffsa_pkg::CMD_SCAN_STEP: begin
				prev_free_q  <= !e_used;
				prev_start_q <= e_start;
				prev_len_q   <= e_len;
			end
			ffsa_pkg::CMD_FAIL: begin
				res_st_q  <= cmd.fail_code;
				res_off_q <= '0;
				res_len_q <= '0;
			end
			ffsa_pkg::CMD_MARK_EXACT: begin
				res_st_q  <= ffsa_pkg::ST_OK;
				res_off_q <= e_start;
				res_len_q <= e_len;
			end
			ffsa_pkg::CMD_SPLIT_PREP, ffsa_pkg::CMD_FREE_MARK: begin
				cur_start_q <= e_start;
				cur_len_q   <= e_len;
			end
			ffsa_pkg::CMD_SPLIT_FIN: begin
				res_st_q  <= ffsa_pkg::ST_OK;
				res_off_q <= cur_start_q;
				res_len_q <= size_q;
			end
			ffsa_pkg::CMD_MERGE: begin
				res_st_q  <= ffsa_pkg::ST_OK;
				res_off_q <= prev_free_q ? prev_start_q : cur_start_q;
				res_len_q <= total;
			end
			ffsa_pkg::CMD_PUBLISH: begin
				status       <= res_st_q;
				block_offset <= res_off_q;
				block_length <= res_len_q;
			end
			default: begin
			end
		endcase
	end

	// segment count stays within the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= MAXC)
		else $error("segment count out of range");
	// a split adds exactly one segment
	a_split_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == ffsa_pkg::CMD_SPLIT_FIN && !cfg_we |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("split did not grow the table");
	// a merge removes at most two segments
	a_merge_d: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == ffsa_pkg::CMD_SHRINK |-> d_q != 2'd3 && {1'b0, d_q} < cnt_q)
		else $error("bad merge removal count");
endmodule
`default_nettype wire

// ----- hw/rtl/ffsa_ctrl.sv -----
// controller: request sequencing over scan, shift and merge phases
`default_nettype none
module ffsa_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire ffsa_pkg::dp_stat_t stat,
	output ffsa_pkg::dp_cmd_t       cmd
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_UP,
		S_MERGE,
		S_DOWN,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath command
	always_comb begin
		state_d       = state_q;
		cmd.op        = ffsa_pkg::CMD_NONE;
		cmd.rd_sel    = ffsa_pkg::RD_IDX;
		cmd.fail_code = ffsa_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = ffsa_pkg::CMD_LOAD;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.is_free && stat.zero_size) begin
					cmd.op        = ffsa_pkg::CMD_FAIL;
					cmd.fail_code = ffsa_pkg::ST_NOFIT;
					state_d       = S_DONE;
				end else if (stat.scan_end) begin
					cmd.op        = ffsa_pkg::CMD_FAIL;
					cmd.fail_code = stat.is_free ? ffsa_pkg::ST_BADFREE : ffsa_pkg::ST_NOFIT;
					state_d       = S_DONE;
				end else if (stat.is_free) begin
					if (stat.hit) begin
						cmd.op  = ffsa_pkg::CMD_FREE_MARK;
						state_d = S_MERGE;
					end else begin
						cmd.op = ffsa_pkg::CMD_SCAN_STEP;
					end
				end else if (stat.fit) begin
					if (stat.exact) begin
						cmd.op  = ffsa_pkg::CMD_MARK_EXACT;
						state_d = S_DONE;
					end else if (stat.full) begin
						cmd.op        = ffsa_pkg::CMD_FAIL;
						cmd.fail_code = ffsa_pkg::ST_FULL;
						state_d       = S_DONE;
					end else begin
						cmd.op  = ffsa_pkg::CMD_SPLIT_PREP;
						state_d = S_UP;
					end
				end else begin
					cmd.op = ffsa_pkg::CMD_SCAN_STEP;
				end
			end
			S_UP: begin
				cmd.rd_sel = ffsa_pkg::RD_KM1;
				if (stat.up_done) begin
					cmd.op  = ffsa_pkg::CMD_SPLIT_FIN;
					state_d = S_DONE;
				end else begin
					cmd.op = ffsa_pkg::CMD_SHIFT_UP;
				end
			end
			S_MERGE: begin
				cmd.rd_sel = ffsa_pkg::RD_NXT;
				cmd.op     = ffsa_pkg::CMD_MERGE;
				state_d    = S_DOWN;
			end
			S_DOWN: begin
				cmd.rd_sel = ffsa_pkg::RD_KD;
				if (stat.dn_done) begin
					cmd.op  = ffsa_pkg::CMD_SHRINK;
					state_d = S_DONE;
				end else begin
					cmd.op = ffsa_pkg::CMD_SHIFT_DOWN;
				end
			end
			S_DONE: begin
				if (!out_valid || out_ready) begin
					cmd.op  = ffsa_pkg::CMD_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == ffsa_pkg::CMD_PUBLISH) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// a result is published only from the done state
	a_pub: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == ffsa_pkg::CMD_PUBLISH |-> state_q == S_DONE)
		else $error("publish outside done state");
	// an accepted request always starts a scan
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_SCAN)
		else $error("accepted request did not start a scan");
	// a publish raises the output valid
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == ffsa_pkg::CMD_PUBLISH |=> out_valid)
		else $error("result not shown after publish");
endmodule
`default_nettype wire

// ----- hw/rtl/first_fit_segment_allocator.sv -----
// top level of the first-fit segment allocator with coalescing
// an allocate scans the entries up to the first fit and, on a split, shifts the later entries up;
//   a free scans to the matching used entry, merges it with free neighbours and shifts entries down
// throughput: one request at a time, set by the single table read port walking the entries
// the next request is taken while the previous result waits in the output register
// reset: asynchronous, leaves one free segment of 1024 units; a config write makes one of cfg_wdata units
`default_nettype none
module first_fit_segment_allocator (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [ffsa_pkg::OFF_W-1:0] cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       req_type,
	input  wire logic [ffsa_pkg::OFF_W-1:0] alloc_length,
	input  wire logic [ffsa_pkg::OFF_W-1:0] free_offset,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      status,
	output logic [ffsa_pkg::OFF_W-1:0]      block_offset,
	output logic [ffsa_pkg::OFF_W-1:0]      block_length
);
	ffsa_pkg::dp_cmd_t  cmd;
	ffsa_pkg::dp_stat_t stat;

	// request sequencing
	ffsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// segment table and arithmetic
	ffsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_type     (req_type),
		.alloc_length (alloc_length),
		.free_offset  (free_offset),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status),
		.block_offset (block_offset),
		.block_length (block_length)
	);
endmodule
`default_nettype wire
